@@ hw/rtl/tap_pkg.sv @@
// Shared types, constants and helpers for the tensor axis permute addresser.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tap_pkg;

  localparam int MAX_DIMS       = 5;
  localparam int INDEX_BITS     = 20;
  localparam int EXTENT_BITS    = 12;
  localparam int ELEM_BITS      = 32;
  localparam int EXT_REG_BITS   = EXTENT_BITS + 1;
  localparam int DIM_BITS       = 3;
  localparam int FIELD_BITS     = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 15;
  localparam int PROD_BITS      = INDEX_BITS + EXT_REG_BITS;
  localparam int TERM_BITS      = INDEX_BITS + EXTENT_BITS;
  localparam int SUM_BITS       = INDEX_BITS + DIM_BITS;

  typedef logic [DIM_BITS-1:0]     dim_t;
  typedef logic [EXT_REG_BITS-1:0] ext_t;
  typedef logic [EXTENT_BITS-1:0]  sub_t;
  typedef logic [INDEX_BITS-1:0]   idx_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NUM_DIMS   = 3'd0,
    REG_EXTENT_0   = 3'd1,
    REG_EXTENT_1   = 3'd2,
    REG_EXTENT_2   = 3'd3,
    REG_EXTENT_3   = 3'd4,
    REG_EXTENT_4   = 3'd5,
    REG_AXIS_ORDER = 3'd6
  } reg_index_t;

  // Dimension count and extents are held in their effective (clamped) form.
  typedef struct packed {
    dim_t                    nd;
    ext_t [MAX_DIMS-1:0]     ext;
    dim_t [MAX_DIMS-1:0]     axis;
  } cfg_t;

  // Output strides modulo 2^INDEX_BITS, with a flag for strides that do not fit.
  typedef struct packed {
    idx_t [MAX_DIMS-1:0]     stride;
    logic [MAX_DIMS-1:0]     big;
  } stride_t;

  function automatic dim_t eff_dims(input logic [DIM_BITS-1:0] v);
    dim_t d;
    d = v;
    if (v == '0) d = dim_t'(1);
    if (v > dim_t'(MAX_DIMS)) d = dim_t'(MAX_DIMS);
    return d;
  endfunction

  function automatic ext_t eff_extent(input ext_t v);
    ext_t e;
    e = v;
    if (v == '0) e = ext_t'(1);
    if (v > ext_t'(1 << EXTENT_BITS)) e = ext_t'(1 << EXTENT_BITS);
    return e;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tap_config.sv @@
// Configuration registers and the output stride sequencer of the addresser.
// Depends on tap_pkg.
`default_nettype none

module tap_config (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output tap_pkg::cfg_t                           cfg,
  output tap_pkg::stride_t                        strides,
  output logic                                    busy
);

  logic                            wr;
  logic                            seq_active;
  tap_pkg::dim_t                   seq_pos;
  tap_pkg::dim_t                   nxt;
  tap_pkg::ext_t                   seq_ext;
  tap_pkg::idx_t                   cur_stride;
  logic                            cur_big;
  logic [tap_pkg::PROD_BITS-1:0]   prod;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;
  assign busy      = seq_active | wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nd <= tap_pkg::dim_t'(1);
      for (int i = 0; i < tap_pkg::MAX_DIMS; i++) begin
        cfg.ext[i]  <= tap_pkg::ext_t'(1);
        cfg.axis[i] <= tap_pkg::dim_t'(i);
      end
    end else if (wr) begin
      case (tap_pkg::reg_index_t'(cfg_index))
        tap_pkg::REG_NUM_DIMS: begin
          cfg.nd <= tap_pkg::eff_dims(cfg_data[tap_pkg::DIM_BITS-1:0]);
        end
        tap_pkg::REG_EXTENT_0: begin
          cfg.ext[0] <= tap_pkg::eff_extent(cfg_data[tap_pkg::EXT_REG_BITS-1:0]);
        end
        tap_pkg::REG_EXTENT_1: begin
          cfg.ext[1] <= tap_pkg::eff_extent(cfg_data[tap_pkg::EXT_REG_BITS-1:0]);
        end
        tap_pkg::REG_EXTENT_2: begin
          cfg.ext[2] <= tap_pkg::eff_extent(cfg_data[tap_pkg::EXT_REG_BITS-1:0]);
        end
        tap_pkg::REG_EXTENT_3: begin
          cfg.ext[3] <= tap_pkg::eff_extent(cfg_data[tap_pkg::EXT_REG_BITS-1:0]);
        end
        tap_pkg::REG_EXTENT_4: begin
          cfg.ext[4] <= tap_pkg::eff_extent(cfg_data[tap_pkg::EXT_REG_BITS-1:0]);
        end
        tap_pkg::REG_AXIS_ORDER: begin
          for (int j = 0; j < tap_pkg::MAX_DIMS; j++) begin
            cfg.axis[j] <= cfg_data[j*tap_pkg::FIELD_BITS +: tap_pkg::FIELD_BITS];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The stride of output position p is the stride of p+1 times the extent
  // that output position p+1 sees, so the positions are filled innermost first.
  always_comb begin
    nxt        = seq_pos + tap_pkg::dim_t'(1);
    seq_ext    = tap_pkg::ext_t'(1);
    cur_stride = '0;
    cur_big    = 1'b0;
    for (int k = 0; k < tap_pkg::MAX_DIMS; k++) begin
      if (tap_pkg::dim_t'(k) == nxt) begin
        cur_stride = strides.stride[k];
        cur_big    = strides.big[k];
        if (nxt < cfg.nd && cfg.axis[k] < cfg.nd) begin
          for (int a = 0; a < tap_pkg::MAX_DIMS; a++) begin
            if (tap_pkg::dim_t'(a) == cfg.axis[k]) seq_ext = cfg.ext[a];
          end
        end
      end
    end
    prod = tap_pkg::PROD_BITS'(cur_stride) * tap_pkg::PROD_BITS'(seq_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_pos    <= '0;
      for (int i = 0; i < tap_pkg::MAX_DIMS; i++) begin
        strides.stride[i] <= tap_pkg::idx_t'(1);
        strides.big[i]    <= 1'b0;
      end
    end else if (wr) begin
      seq_active <= 1'b1;
      seq_pos    <= tap_pkg::dim_t'(tap_pkg::MAX_DIMS - 1);
    end else if (seq_active) begin
      if (seq_pos == tap_pkg::dim_t'(tap_pkg::MAX_DIMS - 1)) begin
        strides.stride[seq_pos] <= tap_pkg::idx_t'(1);
        strides.big[seq_pos]    <= 1'b0;
      end else begin
        strides.stride[seq_pos] <= prod[tap_pkg::INDEX_BITS-1:0];
        strides.big[seq_pos]    <= cur_big
                                   | (|prod[tap_pkg::PROD_BITS-1:tap_pkg::INDEX_BITS]);
      end
      if (seq_pos == '0) seq_active <= 1'b0;
      seq_pos <= seq_pos - tap_pkg::dim_t'(1);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tap_counters.sv @@
// Subscript counters of the input axes, nested increment and last-word detection.
// Depends on tap_pkg.
`default_nettype none

module tap_counters (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tap_pkg::cfg_t                cfg,
  input  wire logic                         advance,
  output tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] out_sub,
  output logic                              done
);

  tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] cnt;
  tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] cnt_next;
  tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] live;
  logic          [tap_pkg::MAX_DIMS-1:0] last;
  logic                                  carry;

  always_comb begin
    for (int i = 0; i < tap_pkg::MAX_DIMS; i++) begin
      live[i] = (tap_pkg::dim_t'(i) < cfg.nd) ? cnt[i] : '0;
      last[i] = ({1'b0, live[i]} + tap_pkg::ext_t'(1)) >= cfg.ext[i];
    end
    carry = 1'b1;
    for (int i = tap_pkg::MAX_DIMS - 1; i >= 0; i--) begin
      if (tap_pkg::dim_t'(i) < cfg.nd) begin
        if (carry) begin
          cnt_next[i] = last[i] ? '0 : live[i] + tap_pkg::sub_t'(1);
        end else begin
          cnt_next[i] = live[i];
        end
        carry = carry & last[i];
      end else begin
        cnt_next[i] = '0;
      end
    end
    done = carry;
    for (int j = 0; j < tap_pkg::MAX_DIMS; j++) begin
      out_sub[j] = '0;
      if (tap_pkg::dim_t'(j) < cfg.nd && cfg.axis[j] < cfg.nd) begin
        for (int a = 0; a < tap_pkg::MAX_DIMS; a++) begin
          if (tap_pkg::dim_t'(a) == cfg.axis[j]) out_sub[j] = live[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (advance) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tap_index.sv @@
// Stride products and their sum, giving the wrapped output index and overflow.
// Depends on tap_pkg.
`default_nettype none

module tap_index (
  input  wire tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] out_sub,
  input  wire tap_pkg::stride_t                      strides,
  output tap_pkg::idx_t                              index,
  output logic                                       overflow
);

  logic [tap_pkg::TERM_BITS-1:0] term [tap_pkg::MAX_DIMS];
  logic [tap_pkg::SUM_BITS-1:0]  sum;
  logic                          term_ovf;

  always_comb begin
    sum      = '0;
    term_ovf = 1'b0;
    for (int j = 0; j < tap_pkg::MAX_DIMS; j++) begin
      term[j] = tap_pkg::TERM_BITS'(out_sub[j]) * tap_pkg::TERM_BITS'(strides.stride[j]);
      if ((strides.big[j] && out_sub[j] != '0)
          || (|term[j][tap_pkg::TERM_BITS-1:tap_pkg::INDEX_BITS])) begin
        term_ovf = 1'b1;
      end
      sum = sum + tap_pkg::SUM_BITS'(term[j][tap_pkg::INDEX_BITS-1:0]);
    end
    index    = sum[tap_pkg::INDEX_BITS-1:0];
    overflow = term_ovf | (|sum[tap_pkg::SUM_BITS-1:tap_pkg::INDEX_BITS]);
  end

endmodule

`default_nettype wire

@@ hw/rtl/tensor_axis_permute_addresser.sv @@
// Top level of the tensor axis permute addresser: configuration, counters, index logic and
// the output register. Depends on tap_pkg, tap_config, tap_counters, tap_index.
//
// Usage: the elements of a tensor enter on the input channel (in_valid,
// in_stall, element_bits) one word per cycle in row-major order. For each
// word the output channel (out_valid, out_stall) carries the row-major index
// of that element in the permuted tensor, the element bits, a flag on the
// tensor's last element and a flag when the index wrapped.
// out_valid rises in the cycle after acceptance. Throughput is one word per
// cycle while in_stall is low, set by the single output register, which
// takes a new word in the same cycle the previous one is taken.
// When the receiver stalls, the result word holds and in_stall rises until
// it is taken. The user must write registers through cfg_valid, cfg_ready,
// cfg_index and cfg_data only while the block is idle; the block does not
// enforce it. Each write restarts the stride sequencer; in_stall stays high
// until it ends. Reset clears the counters, loads the register reset values
// (one dimension, unit extents, identity order) and empties the output register.
`default_nettype none

module tensor_axis_permute_addresser (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [tap_pkg::ELEM_BITS-1:0]      element_bits,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tap_pkg::INDEX_BITS-1:0]          out_index,
  output logic [tap_pkg::ELEM_BITS-1:0]           element_out,
  output logic                                    tensor_done,
  output logic                                    index_overflow
);

  tap_pkg::cfg_t                         cfg;
  tap_pkg::stride_t                      strides;
  tap_pkg::sub_t [tap_pkg::MAX_DIMS-1:0] out_sub;
  tap_pkg::idx_t                         index;
  logic                                  busy;
  logic                                  done;
  logic                                  overflow;
  logic                                  accept;
  logic                                  out_valid_next;

  tap_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .strides   (strides),
    .busy      (busy)
  );

  tap_counters u_counters (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (accept),
    .out_sub (out_sub),
    .done    (done)
  );

  tap_index u_index (
    .out_sub  (out_sub),
    .strides  (strides),
    .index    (index),
    .overflow (overflow)
  );

  assign in_stall       = busy | (out_valid & out_stall);
  assign accept         = in_valid & ~in_stall;
  assign out_valid_next = accept | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_index      <= index;
      element_out    <= element_bits;
      tensor_done    <= done;
      index_overflow <= overflow;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for tensor_axis_permute_addresser. It writes register settings,
// streams element words with random gaps and output stalls, and checks each result word.
// Depends on tap_pkg and the block's RTL.
module tb_top;

  typedef struct packed {
    tap_pkg::idx_t                 out_index;
    logic [tap_pkg::ELEM_BITS-1:0] element_out;
    logic                          tensor_done;
    logic                          index_overflow;
  } placement_t;

  typedef enum bit {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [tap_pkg::CFG_INDEX_BITS-1:0] sel;
    logic [tap_pkg::CFG_DATA_BITS-1:0]  value;
    logic [tap_pkg::ELEM_BITS-1:0]      word;
    logic                               known;
    tap_pkg::idx_t                      want_index;
    logic                               want_done;
    logic                               want_overflow;
  } script_row_t;

  localparam logic [tap_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;
  localparam int NUM_REGS     = 7;
  localparam int RANDOM_WORDS = 1400;
  localparam int MAX_GAP      = 12;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam int SCRIPT_ROWS  = 36;

  // Axis order 17986 puts input axes 2, 0, 1 on output axes 0, 1, 2.
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_WORD,  '0,                      15'd0,     32'h0000_0000, 1'b1, 20'd0, 1'b1, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hFFFF_FFFF, 1'b1, 20'd0, 1'b1, 1'b0},
    '{ROW_WRITE, REG_SPARE,               15'h7FFF,  32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hA5A5_A5A5, 1'b1, 20'd0, 1'b1, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_NUM_DIMS,   15'd0,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_0,   15'd0,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h0000_0001, 1'b1, 20'd0, 1'b1, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_NUM_DIMS,   15'd3,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_0,   15'd2,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_1,   15'd3,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_2,   15'd4,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_AXIS_ORDER, 15'd17986, 32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h8000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h7FFF_FFFF, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h0000_FFFF, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hFFFF_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h1234_5678, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_0,   15'd4096,  32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_1,   15'd8191,  32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_2,   15'd2,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h0F0F_0F0F, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hF0F0_F0F0, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h3333_3333, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hCCCC_CCCC, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_NUM_DIMS,   15'd7,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_3,   15'd4097,  32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_EXTENT_4,   15'd3,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_AXIS_ORDER, 15'h7FFF,  32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h5555_5555, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hAAAA_AAAA, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hDEAD_BEEF, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_NUM_DIMS,   15'd2,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WRITE, tap_pkg::REG_AXIS_ORDER, 15'd4,     32'h0000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h0000_0002, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'h4000_0000, 1'b0, 20'd0, 1'b0, 1'b0},
    '{ROW_WORD,  '0,                      15'd0,     32'hFFFF_FFFE, 1'b0, 20'd0, 1'b0, 1'b0}
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [tap_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [tap_pkg::ELEM_BITS-1:0]      element_bits = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  tap_pkg::idx_t                      out_index;
  logic [tap_pkg::ELEM_BITS-1:0]      element_out;
  logic                               tensor_done;
  logic                               index_overflow;

  logic [tap_pkg::DIM_BITS-1:0]      dims_cfg;
  logic [tap_pkg::EXT_REG_BITS-1:0]  extent_cfg [tap_pkg::MAX_DIMS];
  logic [tap_pkg::CFG_DATA_BITS-1:0] order_cfg;
  tap_pkg::sub_t                     sub_count [tap_pkg::MAX_DIMS];
  placement_t                        expected_placements [$];
  bit                                steady = 1'b0;
  int                                hold_cycles = 0;
  int                                mismatches = 0;
  int                                idle_cycles = 0;

  tensor_axis_permute_addresser i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_dims();
    int d;
    d = int'(dims_cfg);
    if (d == 0) d = 1;
    if (d > tap_pkg::MAX_DIMS) d = tap_pkg::MAX_DIMS;
    return d;
  endfunction

  function automatic int clamp_extent(input logic [tap_pkg::EXT_REG_BITS-1:0] raw);
    int e;
    e = int'(raw);
    if (e == 0) e = 1;
    if (e > (1 << tap_pkg::EXTENT_BITS)) e = 1 << tap_pkg::EXTENT_BITS;
    return e;
  endfunction

  // Places one element in the permuted tensor and steps the subscript counters.
  function automatic placement_t place_word(input logic [tap_pkg::ELEM_BITS-1:0] bits);
    placement_t      p;
    longint unsigned flat;
    int              nd, ax, sub, ext, i, j;
    bit              last, carry;
    nd = active_dims();
    for (i = nd; i < tap_pkg::MAX_DIMS; i++) sub_count[i] = '0;
    flat = 0;
    for (j = 0; j < nd; j++) begin
      ax = int'(order_cfg[tap_pkg::FIELD_BITS*j +: tap_pkg::FIELD_BITS]);
      sub = 0;
      ext = 1;
      if (ax < nd) begin
        sub = int'(sub_count[ax]);
        ext = clamp_extent(extent_cfg[ax]);
      end
      flat = flat * 64'(ext) + 64'(sub);
    end
    last = 1'b1;
    for (i = 0; i < nd; i++) begin
      if (int'(sub_count[i]) + 1 < clamp_extent(extent_cfg[i])) last = 1'b0;
    end
    carry = 1'b1;
    for (i = nd - 1; i >= 0; i--) begin
      if (carry) begin
        if (int'(sub_count[i]) + 1 < clamp_extent(extent_cfg[i])) begin
          sub_count[i] = sub_count[i] + 1'b1;
          carry = 1'b0;
        end else begin
          sub_count[i] = '0;
        end
      end
    end
    p.out_index      = flat[tap_pkg::INDEX_BITS-1:0];
    p.element_out    = bits;
    p.tensor_done    = last;
    p.index_overflow = ((flat >> tap_pkg::INDEX_BITS) != 0);
    return p;
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] want, got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tap_pkg::CFG_INDEX_BITS-1:0] sel,
                           input logic [tap_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (sel)
      tap_pkg::REG_NUM_DIMS: dims_cfg = value[tap_pkg::DIM_BITS-1:0];
      tap_pkg::REG_EXTENT_0, tap_pkg::REG_EXTENT_1, tap_pkg::REG_EXTENT_2,
      tap_pkg::REG_EXTENT_3, tap_pkg::REG_EXTENT_4: begin
        extent_cfg[sel - tap_pkg::REG_EXTENT_0] = value[tap_pkg::EXT_REG_BITS-1:0];
      end
      tap_pkg::REG_AXIS_ORDER: order_cfg = value;
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [tap_pkg::ELEM_BITS-1:0] bits, input bit known,
                           input placement_t typed);
    int         gap;
    placement_t p;
    gap = steady ? 0 : int'($urandom_range(0, MAX_GAP));
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    element_bits <= bits;
    do @(posedge clk); while (in_stall !== 1'b0);
    p = place_word(bits);
    expected_placements.push_back(known ? typed : p);
  endtask

  always @(negedge clk) begin
    out_stall <= (hold_cycles > 0);
  end

  always @(posedge clk) begin
    placement_t want;
    bit         out_taken;
    out_taken = !rst && out_valid === 1'b1 && out_stall === 1'b0;
    if (out_taken) begin
      hold_cycles = steady ? 0 : int'($urandom_range(0, MAX_GAP));
      if (expected_placements.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual index %h element %h",
                 $time, out_index, element_out);
      end else begin
        want = expected_placements.pop_front();
        compare_field("out_index", want.out_index, out_index);
        compare_field("element_out", want.element_out, element_out);
        compare_field("tensor_done", want.tensor_done, tensor_done);
        compare_field("index_overflow", want.index_overflow, index_overflow);
      end
    end else if (hold_cycles > 0) begin
      hold_cycles--;
    end
    if (out_taken || (in_valid && in_stall === 1'b0) || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int                                r, i, k, tmp, sent, words, pick, nd;
    longint                            tensor;
    int                                reg_order [NUM_REGS];
    int                                axes [tap_pkg::MAX_DIMS];
    logic [tap_pkg::EXT_REG_BITS-1:0]  ext_pick [tap_pkg::MAX_DIMS];
    logic [tap_pkg::DIM_BITS-1:0]      dims_pick;
    logic [tap_pkg::CFG_DATA_BITS-1:0] order_pick, value;
    logic [tap_pkg::ELEM_BITS-1:0]     bits;
    placement_t                        typed;
    bit                                write_all;

    dims_cfg  = tap_pkg::dim_t'(1);
    order_cfg = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
    for (i = 0; i < tap_pkg::MAX_DIMS; i++) begin
      extent_cfg[i] = tap_pkg::ext_t'(1);
      sub_count[i]  = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(SCRIPT[r].sel, SCRIPT[r].value);
      end else begin
        typed.out_index      = SCRIPT[r].want_index;
        typed.element_out    = SCRIPT[r].word;
        typed.tensor_done    = SCRIPT[r].want_done;
        typed.index_overflow = SCRIPT[r].want_overflow;
        send_word(SCRIPT[r].word, SCRIPT[r].known, typed);
      end
    end

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);
      pick = int'($urandom_range(0, 3));
      dims_pick = tap_pkg::dim_t'($urandom_range(0, 7));
      for (i = 0; i < tap_pkg::MAX_DIMS; i++) begin
        if (pick == 0) begin
          case ($urandom_range(0, 4))
            0: ext_pick[i] = '0;
            1: ext_pick[i] = tap_pkg::ext_t'(1 << tap_pkg::EXTENT_BITS);
            2: ext_pick[i] = tap_pkg::ext_t'($urandom_range((1 << tap_pkg::EXTENT_BITS) + 1,
                                                            (1 << tap_pkg::EXT_REG_BITS) - 1));
            default: ext_pick[i] = tap_pkg::ext_t'($urandom_range(1, 1 << tap_pkg::EXTENT_BITS));
          endcase
        end else begin
          ext_pick[i] = tap_pkg::ext_t'($urandom_range(0, 5));
        end
      end
      nd = (dims_pick == 0) ? 1
         : ((dims_pick > tap_pkg::MAX_DIMS) ? tap_pkg::MAX_DIMS : int'(dims_pick));
      for (i = 0; i < tap_pkg::MAX_DIMS; i++) axes[i] = i;
      for (i = nd - 1; i > 0; i--) begin
        k = int'($urandom_range(0, i));
        tmp = axes[i];
        axes[i] = axes[k];
        axes[k] = tmp;
      end
      order_pick = tap_pkg::CFG_DATA_BITS'($urandom_range(0, (1 << tap_pkg::CFG_DATA_BITS) - 1));
      if ($urandom_range(0, 3) != 0) begin
        for (i = 0; i < nd; i++) begin
          order_pick[tap_pkg::FIELD_BITS*i +: tap_pkg::FIELD_BITS] = tap_pkg::dim_t'(axes[i]);
        end
      end

      for (i = 0; i < NUM_REGS; i++) reg_order[i] = i;
      for (i = NUM_REGS - 1; i > 0; i--) begin
        k = int'($urandom_range(0, i));
        tmp = reg_order[i];
        reg_order[i] = reg_order[k];
        reg_order[k] = tmp;
      end
      write_all = (sent == 0) || ($urandom_range(0, 1) == 0);
      for (i = 0; i < NUM_REGS; i++) begin
        if (write_all || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            value = tap_pkg::CFG_DATA_BITS'($urandom_range(0, (1 << tap_pkg::CFG_DATA_BITS) - 1));
          end else begin
            value = '0;
          end
          case (reg_order[i])
            tap_pkg::REG_NUM_DIMS: value[tap_pkg::DIM_BITS-1:0] = dims_pick;
            tap_pkg::REG_AXIS_ORDER: value = order_pick;
            default: begin
              value[tap_pkg::EXT_REG_BITS-1:0] = ext_pick[reg_order[i] - tap_pkg::REG_EXTENT_0];
            end
          endcase
          write_reg(tap_pkg::CFG_INDEX_BITS'(reg_order[i]), value);
        end
      end

      nd = active_dims();
      tensor = 1;
      for (i = 0; i < nd; i++) tensor = tensor * longint'(clamp_extent(extent_cfg[i]));
      words = (tensor <= 40) ? int'($urandom_range(1, 2 * int'(tensor) + 3))
                             : int'($urandom_range(8, 60));
      for (i = 0; i < words; i++) begin
        case ($urandom_range(0, 9))
          0: bits = '0;
          1: bits = '1;
          default: bits = $urandom;
        endcase
        send_word(bits, 1'b0, '0);
        sent++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ tensor_axis_permute_addresser.f @@
hw/rtl/tap_pkg.sv
hw/rtl/tap_config.sv
hw/rtl/tap_counters.sv
hw/rtl/tap_index.sv
hw/rtl/tensor_axis_permute_addresser.sv
tb/sv/tb_top.sv
